// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the top level of the byte ring FIFO.
// No dependencies; include by bare file name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold in the same cycle as the trigger.
`define BRF_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Condition must hold in the cycle after the trigger.
`define BRF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/brf_pkg.sv =====
// Package of the byte ring FIFO: operation codes and state machine type.
// No dependencies.
package brf_pkg;

	typedef enum logic [2:0] {
		OP_WRITE = 3'd0,
		OP_READ  = 3'd1,
		OP_PEEK  = 3'd2,
		OP_SKIP  = 3'd3,
		OP_CLEAR = 3'd4
	} op_e_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	localparam int unsigned OP_W    = 3;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned COUNT_W = 7;
	localparam int unsigned LEVEL_W = 8;

endpackage

// ===== hw/rtl/brf_in_if.sv =====
// Request channel of the byte ring FIFO: valid/ready plus the operation payload.
// Depends on brf_pkg for field widths.
interface brf_in_if;
	logic                           valid;
	logic                           ready;
	logic [brf_pkg::OP_W-1:0]       op;
	logic [brf_pkg::BYTE_W-1:0]     wr_data;
	logic [brf_pkg::COUNT_W-1:0]    count;

	modport source (output valid, output op, output wr_data, output count, input ready);
	modport sink (input valid, input op, input wr_data, input count, output ready);
endinterface

// ===== hw/rtl/brf_out_if.sv =====
// Result channel of the byte ring FIFO: valid/ready plus the result payload.
// Depends on brf_pkg for field widths.
interface brf_out_if;
	logic                           valid;
	logic                           ready;
	logic [brf_pkg::BYTE_W-1:0]     rd_data;
	logic                           data_valid;
	logic                           accepted;
	logic [brf_pkg::COUNT_W-1:0]    moved;
	logic [brf_pkg::LEVEL_W-1:0]    level;
	logic [brf_pkg::LEVEL_W-1:0]    free_space;
	logic                           last;

	modport source (output valid, output rd_data, output data_valid, output accepted,
		output moved, output level, output free_space, output last, input ready);
	modport sink (input valid, input rd_data, input data_valid, input accepted,
		input moved, input level, input free_space, input last, output ready);
endinterface

// ===== hw/rtl/brf_mem.sv =====
// Byte storage of the ring FIFO: one write port, one read port, registered read data.
// Depends on brf_pkg for the byte width.
module brf_mem #(
	parameter int unsigned DEPTH  = 256,
	parameter int unsigned ADDR_W = 8
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [ADDR_W-1:0]          waddr,
	input  logic [brf_pkg::BYTE_W-1:0] wdata,
	input  logic                       re,
	input  logic [ADDR_W-1:0]          raddr,
	output logic [brf_pkg::BYTE_W-1:0] rdata
);

	logic [brf_pkg::BYTE_W-1:0] mem_q [DEPTH];
	logic [brf_pkg::BYTE_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read data holds its value while no read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/byte_ring_fifo_with_skip_peek_unit.sv =====
// Top level of the byte ring FIFO with skip and peek.
// Depends on brf_pkg, brf_in_if, brf_out_if, brf_mem and assert_macros.svh.

// A ring of DEPTH byte slots with one slot kept empty, so it holds up to DEPTH-1
// bytes. Each request transaction is one operation: write a byte (dropped when
// full), read or peek a run of up to MAX_BURST bytes, skip up to MAX_BURST
// bytes, or clear. Write, skip, clear and unused codes produce exactly one
// result transaction, and a request of that kind can be taken every cycle
// while the result side is ready. A read or peek of n available bytes
// produces n result transactions, one byte per cycle while the result side is
// ready; an empty read or peek gives one result with moved zero. The single
// read port of the byte memory sets that one-byte-per-cycle figure: the first
// byte is fetched on the cycle the request is accepted and each following
// byte on the cycle the previous result leaves the output register. The next
// request is taken once the last read of the run has been issued. Every
// result carries the level and free space after the whole operation,
// truncated to eight bits. No clearing pass is needed after reset: only bytes
// that were written are ever read.
module byte_ring_fifo_with_skip_peek_unit #(
	parameter int unsigned DEPTH     = 256,
	parameter int unsigned MAX_BURST = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	brf_in_if.sink    req,
	brf_out_if.source rsp
);

	`include "assert_macros.svh"

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CMP_W = (PTR_W > brf_pkg::COUNT_W) ? PTR_W : brf_pkg::COUNT_W;
	localparam int unsigned SUM_W = CMP_W + 1;
	localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(DEPTH - 1);
	localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(DEPTH);
	localparam logic [brf_pkg::COUNT_W-1:0] BURST_MAX = brf_pkg::COUNT_W'(MAX_BURST);

	// Control state.
	brf_pkg::state_t              state_q, state_d;
	logic [PTR_W-1:0]             rd_ptr_q, rd_ptr_d;
	logic [PTR_W-1:0]             wr_ptr_q, wr_ptr_d;
	logic [PTR_W-1:0]             fill_q, fill_d;
	logic [PTR_W-1:0]             run_addr_q, run_addr_d;
	logic [brf_pkg::COUNT_W-1:0]  remain_q, remain_d;
	logic                         out_valid_q, out_valid_d;

	// Output payload register.
	logic                         out_dv_q, out_dv_d;
	logic                         out_acc_q, out_acc_d;
	logic [brf_pkg::COUNT_W-1:0]  out_moved_q, out_moved_d;
	logic [brf_pkg::LEVEL_W-1:0]  out_level_q, out_level_d;
	logic [brf_pkg::LEVEL_W-1:0]  out_free_q, out_free_d;
	logic                         out_last_q, out_last_d;

	// Memory port.
	logic                         mem_we;
	logic                         mem_re;
	logic [PTR_W-1:0]             mem_raddr;
	logic [brf_pkg::BYTE_W-1:0]   mem_rdata;

	// Working values.
	logic                         out_free_slot;
	logic                         accept;
	logic                         full;
	logic [brf_pkg::COUNT_W-1:0]  eff_cnt;
	logic [brf_pkg::COUNT_W-1:0]  n_cnt;
	logic [SUM_W-1:0]             rd_sum;
	logic [SUM_W-1:0]             rd_adv;
	logic [PTR_W-1:0]             rd_ptr_after;
	logic [PTR_W-1:0]             rd_ptr_inc;
	logic [PTR_W-1:0]             wr_ptr_inc;
	logic [PTR_W-1:0]             run_addr_inc;
	logic [PTR_W-1:0]             lvl_new;
	logic [PTR_W-1:0]             free_new;
	logic [PTR_W+7:0]             lvl_ext;
	logic [PTR_W+7:0]             free_ext;
	logic [SUM_W-1:0]             ptr_dist;

	assign out_free_slot = !out_valid_q || rsp.ready;
	assign req.ready     = (state_q == brf_pkg::ST_IDLE) && out_free_slot;
	assign accept        = req.valid && req.ready;
	assign full          = (fill_q == LAST_IDX);

	always_comb begin
		// Saturate the request count, then limit it to what the FIFO holds.
		eff_cnt = (req.count > BURST_MAX) ? BURST_MAX : req.count;
		n_cnt   = (CMP_W'(fill_q) < CMP_W'(eff_cnt)) ? brf_pkg::COUNT_W'(fill_q) : eff_cnt;

		// Read pointer advanced by the run length, wrapped at the ring size.
		rd_sum       = SUM_W'(rd_ptr_q) + SUM_W'(n_cnt);
		rd_adv       = (rd_sum >= DEPTH_S) ? (rd_sum - DEPTH_S) : rd_sum;
		rd_ptr_after = rd_adv[PTR_W-1:0];

		rd_ptr_inc   = (rd_ptr_q == LAST_IDX) ? '0 : (rd_ptr_q + PTR_W'(1));
		wr_ptr_inc   = (wr_ptr_q == LAST_IDX) ? '0 : (wr_ptr_q + PTR_W'(1));
		run_addr_inc = (run_addr_q == LAST_IDX) ? '0 : (run_addr_q + PTR_W'(1));

		// Distance between the pointers; must always equal the fill count.
		ptr_dist = (wr_ptr_q >= rd_ptr_q) ?
			(SUM_W'(wr_ptr_q) - SUM_W'(rd_ptr_q)) :
			(SUM_W'(wr_ptr_q) + DEPTH_S - SUM_W'(rd_ptr_q));
	end

	always_comb begin
		state_d     = state_q;
		rd_ptr_d    = rd_ptr_q;
		wr_ptr_d    = wr_ptr_q;
		fill_d      = fill_q;
		run_addr_d  = run_addr_q;
		remain_d    = remain_q;
		out_valid_d = rsp.ready ? 1'b0 : out_valid_q;

		out_dv_d    = out_dv_q;
		out_acc_d   = out_acc_q;
		out_moved_d = out_moved_q;
		out_level_d = out_level_q;
		out_free_d  = out_free_q;
		out_last_d  = out_last_q;

		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_raddr = run_addr_q;
		lvl_new   = fill_q;

		if (state_q == brf_pkg::ST_RUN) begin
			// Fetch the next byte of the run whenever the output register frees up.
			if (out_free_slot) begin
				mem_re      = 1'b1;
				mem_raddr   = run_addr_q;
				out_valid_d = 1'b1;
				out_last_d  = (remain_q == brf_pkg::COUNT_W'(1));
				run_addr_d  = run_addr_inc;
				remain_d    = remain_q - brf_pkg::COUNT_W'(1);
				if (remain_q == brf_pkg::COUNT_W'(1)) begin
					state_d = brf_pkg::ST_IDLE;
				end
			end
		end else if (accept) begin
			out_valid_d = 1'b1;
			out_dv_d    = 1'b0;
			out_acc_d   = 1'b0;
			out_moved_d = '0;
			out_last_d  = 1'b1;
			unique case (brf_pkg::op_e_t'(req.op))
				brf_pkg::OP_WRITE: begin
					if (!full) begin
						mem_we    = 1'b1;
						wr_ptr_d  = wr_ptr_inc;
						lvl_new   = fill_q + PTR_W'(1);
						out_acc_d = 1'b1;
					end
				end
				brf_pkg::OP_READ, brf_pkg::OP_PEEK: begin
					if (n_cnt != '0) begin
						if (req.op == brf_pkg::OP_READ) begin
							rd_ptr_d = rd_ptr_after;
							lvl_new  = fill_q - PTR_W'(n_cnt);
						end
						// First byte is fetched right away from the old read pointer.
						mem_re      = 1'b1;
						mem_raddr   = rd_ptr_q;
						out_dv_d    = 1'b1;
						out_moved_d = n_cnt;
						out_last_d  = (n_cnt == brf_pkg::COUNT_W'(1));
						run_addr_d  = rd_ptr_inc;
						remain_d    = n_cnt - brf_pkg::COUNT_W'(1);
						if (n_cnt != brf_pkg::COUNT_W'(1)) begin
							state_d = brf_pkg::ST_RUN;
						end
					end
				end
				brf_pkg::OP_SKIP: begin
					rd_ptr_d    = rd_ptr_after;
					lvl_new     = fill_q - PTR_W'(n_cnt);
					out_moved_d = n_cnt;
				end
				brf_pkg::OP_CLEAR: begin
					rd_ptr_d = wr_ptr_q;
					lvl_new  = '0;
				end
				default: begin
					// Unused codes leave the state alone and report the level.
				end
			endcase
			fill_d      = lvl_new;
			free_new    = LAST_IDX - lvl_new;
			lvl_ext     = (PTR_W + 8)'(lvl_new);
			free_ext    = (PTR_W + 8)'(free_new);
			out_level_d = lvl_ext[7:0];
			out_free_d  = free_ext[7:0];
		end

		free_new = LAST_IDX - lvl_new;
		lvl_ext  = (PTR_W + 8)'(lvl_new);
		free_ext = (PTR_W + 8)'(free_new);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= brf_pkg::ST_IDLE;
			rd_ptr_q    <= '0;
			wr_ptr_q    <= '0;
			fill_q      <= '0;
			run_addr_q  <= '0;
			remain_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			rd_ptr_q    <= rd_ptr_d;
			wr_ptr_q    <= wr_ptr_d;
			fill_q      <= fill_d;
			run_addr_q  <= run_addr_d;
			remain_q    <= remain_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		out_dv_q    <= out_dv_d;
		out_acc_q   <= out_acc_d;
		out_moved_q <= out_moved_d;
		out_level_q <= out_level_d;
		out_free_q  <= out_free_d;
		out_last_q  <= out_last_d;
	end

	brf_mem #(
		.DEPTH  (DEPTH),
		.ADDR_W (PTR_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (wr_ptr_q),
		.wdata (req.wr_data),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// The memory read register holds the byte of the current result while stalled.
	assign rsp.valid      = out_valid_q;
	assign rsp.rd_data    = out_dv_q ? mem_rdata : '0;
	assign rsp.data_valid = out_dv_q;
	assign rsp.accepted   = out_acc_q;
	assign rsp.moved      = out_moved_q;
	assign rsp.level      = out_level_q;
	assign rsp.free_space = out_free_q;
	assign rsp.last       = out_last_q;

	// The fill count tracks the pointer distance at all times.
	`BRF_ASSERT_NOW(a_fill_matches_ptrs, clk, arst_n, 1'b1, ptr_dist == SUM_W'(fill_q), "fill count and pointers disagree")
	// A run in progress always has bytes left to fetch and a result on show.
	`BRF_ASSERT_NOW(a_run_has_work, clk, arst_n, state_q == brf_pkg::ST_RUN, (remain_q != '0) && out_valid_q, "run state without pending bytes")
	// A result that is not the last of its run is followed by another result.
	`BRF_ASSERT_NEXT(a_run_continues, clk, arst_n, rsp.valid && !rsp.last, rsp.valid, "read run ended without a last result")
	// No request is taken while a run is still being fetched.
	`BRF_ASSERT_NOW(a_no_accept_in_run, clk, arst_n, state_q == brf_pkg::ST_RUN, !accept, "request taken during a read run")

endmodule

// ===== tb/sv/brf_result_checker.sv =====
// Result checker for the byte ring FIFO: watches both channels, predicts every result.
// Depends on brf_pkg, brf_in_if and brf_out_if; holds its own copy of the ring state.
module brf_result_checker (
	input  logic clk,
	input  logic arst_n,
	brf_in_if    req,
	brf_out_if   rsp,
	output int   fail_count,
	output int   pending_count,
	output int   ops_seen,
	output int   results_seen
);

	localparam int unsigned OP_W       = brf_pkg::OP_W;
	localparam int unsigned BYTE_W     = brf_pkg::BYTE_W;
	localparam int unsigned COUNT_W    = brf_pkg::COUNT_W;
	localparam int unsigned LEVEL_W    = brf_pkg::LEVEL_W;
	localparam int unsigned RING_DEPTH = 256;
	localparam int unsigned BURST_MAX  = 64;

	typedef struct packed {
		logic [BYTE_W-1:0]  rd_data;
		logic               data_valid;
		logic               accepted;
		logic [COUNT_W-1:0] moved;
		logic [LEVEL_W-1:0] level;
		logic [LEVEL_W-1:0] free_space;
		logic               last;
	} fifo_result_t;

	logic [BYTE_W-1:0] ring_mem [RING_DEPTH];
	int unsigned       head;
	int unsigned       tail;
	fifo_result_t      expected_results [$];
	fifo_result_t      got;
	int                mismatches;
	int                op_total;
	int                result_total;

	function automatic int unsigned ring_level();
		return (tail + RING_DEPTH - head) % RING_DEPTH;
	endfunction

	// Level and free space always describe the ring after the whole operation.
	function automatic fifo_result_t make_result(input int unsigned data, input bit valid,
		input bit acc, input int unsigned moved, input bit last);
		fifo_result_t r;
		int unsigned  lv;
		lv           = ring_level();
		r.rd_data    = BYTE_W'(data);
		r.data_valid = valid;
		r.accepted   = acc;
		r.moved      = COUNT_W'(moved);
		r.level      = LEVEL_W'(lv);
		r.free_space = LEVEL_W'(RING_DEPTH - 1 - lv);
		r.last       = last;
		return r;
	endfunction

	task automatic predict_op(input logic [OP_W-1:0] op_code, input logic [BYTE_W-1:0] data,
		input logic [COUNT_W-1:0] cnt);
		int unsigned want;
		int unsigned n;
		int unsigned start;
		int unsigned nxt;
		want = (cnt > BURST_MAX) ? BURST_MAX : cnt;
		n    = (ring_level() < want) ? ring_level() : want;
		case (op_code)
			brf_pkg::OP_WRITE: begin
				nxt = (tail + 1) % RING_DEPTH;
				if (nxt == head) begin
					expected_results.push_back(make_result(0, 0, 0, 0, 1));
				end else begin
					ring_mem[tail] = data;
					tail = nxt;
					expected_results.push_back(make_result(0, 0, 1, 0, 1));
				end
			end
			brf_pkg::OP_READ, brf_pkg::OP_PEEK: begin
				if (n == 0) begin
					expected_results.push_back(make_result(0, 0, 0, 0, 1));
				end else begin
					start = head;
					if (op_code == brf_pkg::OP_READ)
						head = (head + n) % RING_DEPTH;
					for (int unsigned i = 0; i < n; i++)
						expected_results.push_back(make_result(ring_mem[(start + i) % RING_DEPTH],
							1, 0, n, (i + 1 == n)));
				end
			end
			brf_pkg::OP_SKIP: begin
				head = (head + n) % RING_DEPTH;
				expected_results.push_back(make_result(0, 0, 0, n, 1));
			end
			brf_pkg::OP_CLEAR: begin
				head = tail;
				expected_results.push_back(make_result(0, 0, 0, 0, 1));
			end
			default: begin
				expected_results.push_back(make_result(0, 0, 0, 0, 1));
			end
		endcase
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] seen,
		input logic [31:0] want);
		mismatches++;
		$display("mismatch at %0t: %s is %0h, expected %0h", $time, what, seen, want);
	endtask

	task automatic compare_result(input fifo_result_t r);
		fifo_result_t e;
		if (expected_results.size() == 0) begin
			report_mismatch("unexpected result, last", r.last, 0);
		end else begin
			e = expected_results.pop_front();
			if (r.rd_data !== e.rd_data)       report_mismatch("rd_data", r.rd_data, e.rd_data);
			if (r.data_valid !== e.data_valid) report_mismatch("data_valid", r.data_valid, e.data_valid);
			if (r.accepted !== e.accepted)     report_mismatch("accepted", r.accepted, e.accepted);
			if (r.moved !== e.moved)           report_mismatch("moved", r.moved, e.moved);
			if (r.level !== e.level)           report_mismatch("level", r.level, e.level);
			if (r.free_space !== e.free_space) report_mismatch("free_space", r.free_space, e.free_space);
			if (r.last !== e.last)             report_mismatch("last", r.last, e.last);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head = 0;
			tail = 0;
			expected_results.delete();
		end else begin
			if (req.valid === 1'b1 && req.ready === 1'b1) begin
				predict_op(req.op, req.wr_data, req.count);
				op_total++;
			end
			if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
				got = '{rsp.rd_data, rsp.data_valid, rsp.accepted, rsp.moved,
					rsp.level, rsp.free_space, rsp.last};
				compare_result(got);
				result_total++;
			end
		end
		pending_count <= expected_results.size();
		fail_count    <= mismatches;
		ops_seen      <= op_total;
		results_seen  <= result_total;
	end

	initial begin
		mismatches    = 0;
		op_total      = 0;
		result_total  = 0;
		pending_count = 0;
		fail_count    = 0;
		ops_seen      = 0;
		results_seen  = 0;
	end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the byte ring FIFO testbench: clock, reset, request and result traffic, verdict.
// Depends on brf_pkg, brf_in_if, brf_out_if, brf_result_checker and the unit under test.
module testbench;

	localparam int unsigned OP_W    = brf_pkg::OP_W;
	localparam int unsigned BYTE_W  = brf_pkg::BYTE_W;
	localparam int unsigned COUNT_W = brf_pkg::COUNT_W;

	// Codes 5 to 7 are not operations; the block must answer them with a plain status result.
	localparam logic [OP_W-1:0] OP_RSVD5 = 3'd5;
	localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
	localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;

	localparam int IDLE_PCT    = 17;
	localparam int HOLD_CYCLES = 300;
	// More writes than the ring can hold, so the full case is reached from any level.
	localparam int FILL_WRITES = 262;

	logic clk;
	logic arst_n;

	brf_in_if  req ();
	brf_out_if rsp ();

	int fail_count;
	int pending_count;
	int ops_seen;
	int results_seen;
	int items_sent;

	// Set by the stimulus: quiet turns idling off on both sides, fill_phase starts
	// the long result hold-off.
	bit quiet;
	bit fill_phase;

	logic [OP_W-1:0] spare_ops [3] = '{OP_RSVD5, OP_RSVD6, OP_RSVD7};

	byte_ring_fifo_with_skip_peek_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	brf_result_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.req           (req),
		.rsp           (rsp),
		.fail_count    (fail_count),
		.pending_count (pending_count),
		.ops_seen      (ops_seen),
		.results_seen  (results_seen)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Result side. Ready changes only at the falling edge. The first time the fill
	// phase is seen, ready is held low for a long stretch so that the output register
	// stays occupied and the block has to stall its request side.
	initial begin : result_sink
		int hold_left;
		bit held;
		hold_left = 0;
		held      = 1'b0;
		rsp.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (fill_phase && !held) begin
				held      = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				rsp.ready <= 1'b0;
				hold_left--;
			end else if (quiet) begin
				rsp.ready <= 1'b1;
			end else begin
				rsp.ready <= ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// One request transaction. Idle cycles are inserted at random before it, with
	// noise on the payload while valid is low. Valid stays high after acceptance
	// until the next call drives it again, so it is assigned once per falling edge.
	task automatic send_item(input logic [OP_W-1:0] op_code, input logic [BYTE_W-1:0] data,
		input logic [COUNT_W-1:0] cnt);
		@(negedge clk);
		while (!quiet && $urandom_range(99) < IDLE_PCT) begin
			req.valid   <= 1'b0;
			req.op      <= OP_W'($urandom);
			req.wr_data <= BYTE_W'($urandom);
			req.count   <= COUNT_W'($urandom);
			@(negedge clk);
		end
		req.valid   <= 1'b1;
		req.op      <= op_code;
		req.wr_data <= data;
		req.count   <= cnt;
		@(posedge clk);
		while (req.ready !== 1'b1)
			@(posedge clk);
		items_sent++;
	endtask

	// Mostly small counts, with zero, medium and above-burst counts mixed in.
	function automatic logic [COUNT_W-1:0] random_count();
		int r;
		r = $urandom_range(99);
		if (r < 5)
			return '0;
		else if (r < 80)
			return COUNT_W'($urandom_range(1, 16));
		else if (r < 92)
			return COUNT_W'($urandom_range(17, 64));
		else
			return COUNT_W'($urandom_range(65, 127));
	endfunction

	// Random traffic shaped like real use: bursts of byte writes interleaved with
	// reads, peeks and skips, plus the odd clear and reserved code.
	task automatic send_random_traffic(input int quota);
		int done;
		int kind;
		int burst;
		done = 0;
		while (done < quota) begin
			kind = $urandom_range(99);
			if (kind < 45) begin
				burst = $urandom_range(1, 24);
				repeat (burst)
					send_item(brf_pkg::OP_WRITE, BYTE_W'($urandom), COUNT_W'($urandom));
				done += burst;
			end else begin
				if (kind < 63)
					send_item(brf_pkg::OP_READ, BYTE_W'($urandom), random_count());
				else if (kind < 77)
					send_item(brf_pkg::OP_PEEK, BYTE_W'($urandom), random_count());
				else if (kind < 91)
					send_item(brf_pkg::OP_SKIP, BYTE_W'($urandom), random_count());
				else if (kind < 94)
					send_item(brf_pkg::OP_CLEAR, BYTE_W'($urandom), random_count());
				else
					send_item(spare_ops[$urandom_range(2)], BYTE_W'($urandom),
						random_count());
				done++;
			end
		end
	endtask

	initial begin : stimulus
		req.valid   = 1'b0;
		req.op      = brf_pkg::OP_WRITE;
		req.wr_data = '0;
		req.count   = '0;
		arst_n      = 1'b0;
		quiet       = 1'b0;
		fill_phase  = 1'b0;
		items_sent  = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part. Operations on an empty ring give a single no-data result.
		send_item(brf_pkg::OP_READ, 8'h00, 7'd1);
		send_item(brf_pkg::OP_PEEK, 8'hFF, 7'd64);
		send_item(brf_pkg::OP_SKIP, 8'h00, 7'd5);
		// Data extremes and alternating patterns.
		send_item(brf_pkg::OP_WRITE, 8'h00, 7'd0);
		send_item(brf_pkg::OP_WRITE, 8'hFF, 7'd127);
		send_item(brf_pkg::OP_WRITE, 8'hA5, 7'd0);
		send_item(brf_pkg::OP_WRITE, 8'h5A, 7'd0);
		send_item(brf_pkg::OP_WRITE, 8'h3C, 7'd0);
		send_item(brf_pkg::OP_PEEK, 8'h00, 7'd3);
		// A zero count behaves like an empty ring even with data held.
		send_item(brf_pkg::OP_READ, 8'h00, 7'd0);
		send_item(brf_pkg::OP_PEEK, 8'h00, 7'd0);
		send_item(brf_pkg::OP_SKIP, 8'h00, 7'd0);
		send_item(brf_pkg::OP_READ, 8'h00, 7'd2);
		send_item(brf_pkg::OP_SKIP, 8'h00, 7'd1);
		// Reserved codes leave the state alone.
		send_item(OP_RSVD5, 8'hFF, 7'd127);
		send_item(OP_RSVD6, 8'h00, 7'd64);
		send_item(OP_RSVD7, 8'h81, 7'd1);
		// A count above the burst limit saturates; here the level limits it further.
		send_item(brf_pkg::OP_WRITE, 8'h81, 7'd0);
		send_item(brf_pkg::OP_READ, 8'h00, 7'd127);
		// Clear drops whatever is held.
		send_item(brf_pkg::OP_WRITE, 8'h11, 7'd0);
		send_item(brf_pkg::OP_WRITE, 8'h22, 7'd0);
		send_item(brf_pkg::OP_CLEAR, 8'h00, 7'd64);
		send_item(brf_pkg::OP_READ, 8'h00, 7'd4);

		send_random_traffic(110);

		// Stop offering requests and let every outstanding result drain before the
		// fill starts.
		@(negedge clk);
		req.valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_count != 0);

		// Fill past capacity while the result side is held off, so both the full
		// ring and a stalled request side are seen. The pointers are mid-ring by
		// now, so the full ring straddles the wrap point.
		fill_phase = 1'b1;
		repeat (FILL_WRITES)
			send_item(brf_pkg::OP_WRITE, BYTE_W'($urandom), COUNT_W'($urandom));

		// Drain a full ring at full rate in long saturated runs, with no idling at all.
		quiet = 1'b1;
		send_item(brf_pkg::OP_PEEK, BYTE_W'($urandom), 7'd127);
		repeat (4)
			send_item(brf_pkg::OP_READ, BYTE_W'($urandom), COUNT_W'($urandom_range(64, 127)));
		send_item(brf_pkg::OP_SKIP, BYTE_W'($urandom), 7'd100);
		quiet = 1'b0;

		send_random_traffic(60);

		@(negedge clk);
		req.valid <= 1'b0;

		do
			@(posedge clk);
		while (pending_count != 0);
		// Keep the clock running so that any stray result would still be caught.
		repeat (20) @(posedge clk);

		$display("Summary: %0d operations sent, %0d seen by the checker, %0d results compared.",
			items_sent, ops_seen, results_seen);
		$display("Covered empty and zero-count runs, saturated counts, reserved codes, %s",
			"a full ring under output stall, and wrap-around drains.");
		if (fail_count == 0 && pending_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// Guard against a hung block.
	initial begin : watchdog
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
